/* design/bdlp_pkg.sv */
// Shared types and codes for the button debounce / long press / repeat block.
// No dependencies; every other file in this folder refers to it by scoped names.
package bdlp_pkg;

  localparam int TIME_W = 32;
  localparam int MS_W   = 16;
  localparam int MODE_W = 3;
  localparam int IDX_W  = 3;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DEBOUNCE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CONFIRMED = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HELD      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REPEAT    = 3'd4;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_ACTIVE_HIGH  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_DEBOUNCE     = 3'd1;
  localparam logic [IDX_W-1:0] CFG_LONG_PRESS   = 3'd2;
  localparam logic [IDX_W-1:0] CFG_REPEAT_START = 3'd3;
  localparam logic [IDX_W-1:0] CFG_REPEAT_ACCEL = 3'd4;
  localparam logic [IDX_W-1:0] CFG_REPEAT_FAST  = 3'd5;

  // configuration reset values
  localparam logic [MS_W-1:0] RST_DEBOUNCE     = 16'd50;
  localparam logic [MS_W-1:0] RST_LONG_PRESS   = 16'd1000;
  localparam logic [MS_W-1:0] RST_REPEAT_START = 16'd500;
  localparam logic [MS_W-1:0] RST_REPEAT_ACCEL = 16'd2000;
  localparam logic [MS_W-1:0] RST_REPEAT_FAST  = 16'd100;

  typedef struct packed {
    logic            active_high;
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] long_press_ms;
    logic [MS_W-1:0] repeat_start_ms;
    logic [MS_W-1:0] repeat_accel_ms;
    logic [MS_W-1:0] repeat_fast_ms;
  } cfg_t;

  typedef struct packed {
    logic              short_press;
    logic              long_press;
    logic              repeat_event;
    logic              is_pressed;
    logic [MODE_W-1:0] state_code;
    logic [TIME_W-1:0] pressed_duration;
  } res_t;

endpackage

/* design/bdlp_cfg.sv */
// Configuration register file for the button block.
// Depends on bdlp_pkg for the register indexes, reset values and cfg_t.
module bdlp_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bdlp_pkg::IDX_W-1:0] cfg_index,
  input  logic [bdlp_pkg::MS_W-1:0]  cfg_data,
  output bdlp_pkg::cfg_t             cfg
);

  bdlp_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.active_high     <= 1'b0;
      regs.debounce_ms     <= bdlp_pkg::RST_DEBOUNCE;
      regs.long_press_ms   <= bdlp_pkg::RST_LONG_PRESS;
      regs.repeat_start_ms <= bdlp_pkg::RST_REPEAT_START;
      regs.repeat_accel_ms <= bdlp_pkg::RST_REPEAT_ACCEL;
      regs.repeat_fast_ms  <= bdlp_pkg::RST_REPEAT_FAST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdlp_pkg::CFG_ACTIVE_HIGH:  regs.active_high     <= cfg_data[0];
        bdlp_pkg::CFG_DEBOUNCE:     regs.debounce_ms     <= cfg_data;
        bdlp_pkg::CFG_LONG_PRESS:   regs.long_press_ms   <= cfg_data;
        bdlp_pkg::CFG_REPEAT_START: regs.repeat_start_ms <= cfg_data;
        bdlp_pkg::CFG_REPEAT_ACCEL: regs.repeat_accel_ms <= cfg_data;
        bdlp_pkg::CFG_REPEAT_FAST:  regs.repeat_fast_ms  <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  assign cfg = regs;

endmodule

/* design/bdlp_fsm.sv */
// Press state machine: holds mode, press start, last repeat time and flags,
// and forms one result per poll. Depends on bdlp_pkg for codes and types.
module bdlp_fsm (
  input  logic                        clk,
  input  logic                        rst,
  input  bdlp_pkg::cfg_t              cfg,
  input  logic                        advance,
  input  logic                        pin_level,
  input  logic [bdlp_pkg::TIME_W-1:0] now_ms,
  output bdlp_pkg::res_t              res
);

  localparam int PAD_W = bdlp_pkg::TIME_W - bdlp_pkg::MS_W;

  logic [bdlp_pkg::MODE_W-1:0] mode, mode_next;
  logic                        pressed_flag, pressed_flag_next;
  logic [bdlp_pkg::TIME_W-1:0] press_start, press_start_next;
  logic [bdlp_pkg::TIME_W-1:0] last_repeat, last_repeat_next;
  logic                        long_fired, long_fired_next;

  logic                        pressed;
  logic [bdlp_pkg::TIME_W-1:0] held, since_rep;
  logic ge_debounce, ge_long, ge_start, ge_accel, rep_slow, rep_fast, rep_due;
  logic ev_short, ev_long, ev_rep, started;

  assign pressed   = cfg.active_high ? pin_level : !pin_level;
  assign held      = now_ms - press_start;
  assign since_rep = now_ms - last_repeat;

  // all threshold compares run in parallel; selection happens afterwards
  assign ge_debounce = held >= {{PAD_W{1'b0}}, cfg.debounce_ms};
  assign ge_long     = held >= {{PAD_W{1'b0}}, cfg.long_press_ms};
  assign ge_start    = held >= {{PAD_W{1'b0}}, cfg.repeat_start_ms};
  assign ge_accel    = held >= {{PAD_W{1'b0}}, cfg.repeat_accel_ms};
  assign rep_slow    = since_rep >= {{PAD_W{1'b0}}, cfg.repeat_start_ms};
  assign rep_fast    = since_rep >= {{PAD_W{1'b0}}, cfg.repeat_fast_ms};
  assign rep_due     = ge_accel ? rep_fast : rep_slow;

  always_comb begin
    mode_next         = mode;
    pressed_flag_next = pressed_flag;
    press_start_next  = press_start;
    last_repeat_next  = last_repeat;
    long_fired_next   = long_fired;
    ev_short          = 1'b0;
    ev_long           = 1'b0;
    ev_rep            = 1'b0;
    started           = 1'b0;
    unique case (mode)
      bdlp_pkg::MODE_DEBOUNCE: begin
        if (!pressed) begin
          mode_next         = bdlp_pkg::MODE_IDLE;
          pressed_flag_next = 1'b0;
        end else if (ge_debounce) begin
          mode_next = bdlp_pkg::MODE_CONFIRMED;
        end
      end
      bdlp_pkg::MODE_CONFIRMED: begin
        if (!pressed) begin
          mode_next         = bdlp_pkg::MODE_IDLE;
          pressed_flag_next = 1'b0;
          ev_short          = !long_fired;
        end else if (ge_long && !long_fired) begin
          long_fired_next = 1'b1;
          ev_long         = 1'b1;
          mode_next       = bdlp_pkg::MODE_HELD;
        end else if (ge_start) begin
          mode_next        = bdlp_pkg::MODE_REPEAT;
          last_repeat_next = now_ms;
        end
      end
      bdlp_pkg::MODE_HELD: begin
        if (!pressed) begin
          mode_next         = bdlp_pkg::MODE_IDLE;
          pressed_flag_next = 1'b0;
        end
      end
      bdlp_pkg::MODE_REPEAT: begin
        if (!pressed) begin
          mode_next         = bdlp_pkg::MODE_IDLE;
          pressed_flag_next = 1'b0;
        end else begin
          if (rep_due) begin
            last_repeat_next = now_ms;
            ev_rep           = 1'b1;
          end
          if (ge_long && !long_fired) begin
            long_fired_next = 1'b1;
            ev_long         = 1'b1;
          end
        end
      end
      default: begin
        // idle, and any unused code acts as idle
        mode_next = bdlp_pkg::MODE_IDLE;
        if (pressed) begin
          mode_next         = bdlp_pkg::MODE_DEBOUNCE;
          pressed_flag_next = 1'b1;
          press_start_next  = now_ms;
          long_fired_next   = 1'b0;
          started           = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    res.short_press  = ev_short;
    res.long_press   = ev_long;
    res.repeat_event = ev_rep;
    res.is_pressed   = pressed_flag_next;
    res.state_code   = mode_next;
    // a fresh press restarts the clock at this poll, so its duration is zero
    res.pressed_duration = (pressed_flag_next && !started) ? held : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= bdlp_pkg::MODE_IDLE;
      pressed_flag <= 1'b0;
      press_start  <= '0;
      last_repeat  <= '0;
      long_fired   <= 1'b0;
    end else if (advance) begin
      mode         <= mode_next;
      pressed_flag <= pressed_flag_next;
      press_start  <= press_start_next;
      last_repeat  <= last_repeat_next;
      long_fired   <= long_fired_next;
    end
  end

  a_flag_tracks_mode: assert property (@(posedge clk) disable iff (rst)
    pressed_flag == (mode != bdlp_pkg::MODE_IDLE))
    else $error("pressed flag out of step with mode");

  a_short_goes_idle: assert property (@(posedge clk) disable iff (rst)
    advance && ev_short |=> mode == bdlp_pkg::MODE_IDLE && !long_fired)
    else $error("short press without return to idle");

  a_long_once: assert property (@(posedge clk) disable iff (rst)
    advance && ev_long |=> long_fired && !ev_long)
    else $error("long press not latched or fired twice");

endmodule

/* design/button_debounce_long_press_repeat_top.sv */
// Top level of the button debounce / long press / auto-repeat block.
// An accepted item waits in the input register; its result is captured in the
// result register as the state machine steps, and is held there until taken.
// The block takes one item per cycle while the result side keeps ready high.
// The press state machine updates once per item, as it moves from the input
// register to the result register.
// Reset (rst, synchronous) clears valid bits and state and reloads configuration defaults.
module button_debounce_long_press_repeat_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bdlp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [bdlp_pkg::MS_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         pin_level,
  input  logic [bdlp_pkg::TIME_W-1:0]  now_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         short_press,
  output logic                         long_press,
  output logic                         repeat_event,
  output logic                         is_pressed,
  output logic [bdlp_pkg::MODE_W-1:0]  state_code,
  output logic [bdlp_pkg::TIME_W-1:0]  pressed_duration
);

  bdlp_pkg::cfg_t cfg;
  bdlp_pkg::res_t res, res_q;

  // input register: one polled item waiting for the state machine
  logic                        s1_valid;
  logic                        s1_pin;
  logic [bdlp_pkg::TIME_W-1:0] s1_now;
  logic                        advance;

  // move the held item forward whenever the result register is free or drains
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  bdlp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdlp_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .advance   (advance),
    .pin_level (s1_pin),
    .now_ms    (s1_now),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // payload needs no reset; load only on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pin <= pin_level;
      s1_now <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the result until taken; capture a new one as the state machine steps
  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign short_press      = res_q.short_press;
  assign long_press       = res_q.long_press;
  assign repeat_event     = res_q.repeat_event;
  assign is_pressed       = res_q.is_pressed;
  assign state_code       = res_q.state_code;
  assign pressed_duration = res_q.pressed_duration;

  a_stall_keeps_item: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("input item dropped while stalled");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register empty after advance");

endmodule
